@@ rtl/core/circle_octant_rasterizer_macros.svh @@
// Assertion helpers shared by the rasterizer modules.
// They expect clk_i and rst_ni in the enclosing module.
`ifndef CIRCLE_OCTANT_RASTERIZER_MACROS_SVH
`define CIRCLE_OCTANT_RASTERIZER_MACROS_SVH

// Checked on every edge outside of reset.
`define COR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define COR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/core/cor_pkg.sv @@
`timescale 1ns / 1ps

package cor_pkg;

  localparam int RadiusBits = 11;
  localparam int DecW       = 16;
  localparam int CenterW    = 11;
  localparam int CoordW     = 13;
  localparam int ColorW     = 4;
  localparam int CfgAddrW   = 2;
  localparam int CfgDataW   = 11;
  localparam int FifoDepth  = 2;
  localparam int FifoPtrW   = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int FifoCntW   = $clog2(FifoDepth + 1);

  localparam logic [CenterW-1:0] CenterXReset = CenterW'(500);
  localparam logic [CenterW-1:0] CenterYReset = CenterW'(400);
  localparam logic [ColorW-1:0]  ColorReset   = ColorW'(14);

  typedef enum logic {
    OpStart = 1'b0,
    OpStep  = 1'b1
  } op_e;

  typedef enum logic {
    ModeBresenham = 1'b0,
    ModeMidpoint  = 1'b1
  } algo_mode_e;

  typedef enum logic [CfgAddrW-1:0] {
    CfgCenterX    = 2'd0,
    CfgCenterY    = 2'd1,
    CfgAlgoMode   = 2'd2,
    CfgPixelColor = 2'd3
  } cfg_idx_e;

  // One octant point handed from the front to the back.
  typedef struct packed {
    logic [RadiusBits-1:0] x;
    logic [RadiusBits-1:0] y;
    logic                  last_circle;
  } point_t;

endpackage

@@ rtl/core/circle_octant_rasterizer.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Handshake              Payload
// in       in   in_valid_i/in_ready_o   opcode_i, radius_i
// cfg      in   cfg_valid_i/cfg_ready_o cfg_addr_i, cfg_data_i
// out      out  out_valid_o/out_ready_i pixel_x_o, pixel_y_o, color_out_o,
//                                       last_of_point_o, last_of_circle_o
//
// A start beat yields nothing; a step beat while a circle runs yields eight
// pixel beats, one per cycle from the back end while out is not stalled.
// The front registers each decision update and parks points in a
// two-entry queue, so it keeps taking beats while the back drains pixels.
// Reset clears the point state and the queue; registers return to defaults.
// A stalled out channel holds its beat and backs up into the queue, then in.

module circle_octant_rasterizer import cor_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     opcode_i,
  input  logic [RadiusBits-1:0]    radius_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgAddrW-1:0]      cfg_addr_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [CoordW-1:0] pixel_x_o,
  output logic signed [CoordW-1:0] pixel_y_o,
  output logic [ColorW-1:0]        color_out_o,
  output logic                     last_of_point_o,
  output logic                     last_of_circle_o
);

  logic [CenterW-1:0] center_x_q, center_y_q;
  algo_mode_e         algo_mode_q;
  logic [ColorW-1:0]  color_q;

  logic   push, pop, fifo_valid, fifo_full;
  point_t push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q  <= CenterXReset;
      center_y_q  <= CenterYReset;
      algo_mode_q <= ModeBresenham;
      color_q     <= ColorReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CfgCenterX:    center_x_q  <= cfg_data_i[CenterW-1:0];
        CfgCenterY:    center_y_q  <= cfg_data_i[CenterW-1:0];
        CfgAlgoMode:   algo_mode_q <= algo_mode_e'(cfg_data_i[0]);
        CfgPixelColor: color_q     <= cfg_data_i[ColorW-1:0];
        default:       ;
      endcase
    end
  end

  cor_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .radius_i    (radius_i),
    .algo_mode_i (algo_mode_q),
    .full_i      (fifo_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  cor_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (fifo_valid),
    .full_o      (fifo_full),
    .pop_data_o  (pop_data)
  );

  cor_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pt_valid_i       (fifo_valid),
    .pt_i             (pop_data),
    .pt_pop_o         (pop),
    .center_x_i       (center_x_q),
    .center_y_i       (center_y_q),
    .color_i          (color_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pixel_x_o        (pixel_x_o),
    .pixel_y_o        (pixel_y_o),
    .color_out_o      (color_out_o),
    .last_of_point_o  (last_of_point_o),
    .last_of_circle_o (last_of_circle_o)
  );

endmodule

@@ rtl/core/cor_front.sv @@
`timescale 1ns / 1ps

module cor_front import cor_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic [RadiusBits-1:0] radius_i,
  input  algo_mode_e            algo_mode_i,
  input  logic                  full_i,
  output logic                  push_o,
  output point_t                push_data_o
);

  logic [RadiusBits-1:0] cur_x_q, cur_x_d;
  logic [RadiusBits-1:0] cur_y_q, cur_y_d;
  logic [DecW-1:0]       dec_q, dec_d;
  logic                  running_q, running_d;

  logic                  accept;
  logic [DecW-1:0]       x_w, y_w, diff_w, inc, r_w, dec_start;
  logic                  dec_neg;
  logic [RadiusBits:0]   nx, ny;
  logic                  last_c;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    x_w     = DecW'(cur_x_q);
    y_w     = DecW'(cur_y_q);
    diff_w  = x_w - y_w;
    dec_neg = dec_q[DecW-1];
    unique case (algo_mode_i)
      ModeMidpoint:  inc = dec_neg ? (x_w << 1) + DecW'(3) : (diff_w << 1) + DecW'(5);
      ModeBresenham: inc = dec_neg ? (x_w << 2) + DecW'(6) : (diff_w << 2) + DecW'(10);
      default:       inc = '0;
    endcase
    nx     = {1'b0, cur_x_q} + (RadiusBits + 1)'(1);
    // ny is signed: y, or y - 1 which may reach -1
    ny     = {1'b0, cur_y_q} - (RadiusBits + 1)'(!dec_neg);
    last_c = $signed({1'b0, nx}) > $signed({ny[RadiusBits], ny});

    r_w = DecW'(radius_i);
    unique case (algo_mode_i)
      ModeMidpoint:  dec_start = DecW'(1) - r_w;
      ModeBresenham: dec_start = DecW'(3) - (r_w << 1);
      default:       dec_start = '0;
    endcase
  end

  always_comb begin
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    dec_d     = dec_q;
    running_d = running_q;
    push_o    = 1'b0;
    push_data_o.x           = cur_x_q;
    push_data_o.y           = cur_y_q;
    push_data_o.last_circle = last_c;
    if (accept) begin
      if (op_e'(opcode_i) == OpStart) begin
        cur_x_d   = '0;
        cur_y_d   = radius_i;
        dec_d     = dec_start;
        running_d = 1'b1;
      end else if (running_q) begin
        push_o    = 1'b1;
        dec_d     = dec_q + inc;
        cur_x_d   = nx[RadiusBits-1:0];
        cur_y_d   = ny[RadiusBits] ? '0 : ny[RadiusBits-1:0];
        running_d = !last_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      dec_q     <= '0;
      running_q <= 1'b0;
    end else begin
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      dec_q     <= dec_d;
      running_q <= running_d;
    end
  end

endmodule

@@ rtl/core/cor_fifo.sv @@
`timescale 1ns / 1ps
`include "circle_octant_rasterizer_macros.svh"

module cor_fifo import cor_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  point_t push_data_i,
  input  logic   pop_i,
  output logic   valid_o,
  output logic   full_o,
  output point_t pop_data_o
);

  point_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0]   count_q, count_d;

  assign valid_o    = count_q != '0;
  assign full_o     = count_q == FifoCntW'(FifoDepth);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + FifoPtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + FifoPtrW'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + FifoCntW'(1);
      2'b01:   count_d = count_q - FifoCntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `COR_ASSERT_ALWAYS(a_fifo_count_bound, count_q <= FifoCntW'(FifoDepth), "fifo count overrun")
  `COR_ASSERT(a_fifo_no_underflow, pop_i |-> count_q != '0, "fifo pop while empty")
  `COR_ASSERT(a_fifo_no_overflow, push_i && !pop_i |-> !full_o, "fifo push while full")

endmodule

@@ rtl/core/cor_back.sv @@
`timescale 1ns / 1ps
`include "circle_octant_rasterizer_macros.svh"

module cor_back import cor_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     pt_valid_i,
  input  point_t                   pt_i,
  output logic                     pt_pop_o,
  input  logic [CenterW-1:0]       center_x_i,
  input  logic [CenterW-1:0]       center_y_i,
  input  logic [ColorW-1:0]        color_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [CoordW-1:0] pixel_x_o,
  output logic signed [CoordW-1:0] pixel_y_o,
  output logic [ColorW-1:0]        color_out_o,
  output logic                     last_of_point_o,
  output logic                     last_of_circle_o
);

  point_t              pt_q, pt_d;
  logic                busy_q, busy_d;
  logic [2:0]          k_q, k_d;
  logic                out_valid_q, out_valid_d;
  logic [CoordW-1:0]   pix_x_q, pix_y_q;
  logic [ColorW-1:0]   color_q;
  logic                lastp_q, lastc_q;

  logic                adv;
  logic [CoordW-1:0]   xs, ys, px, py, sx, sy;

  assign adv      = busy_q && (!out_valid_q || out_ready_i);
  assign pt_pop_o = pt_valid_i && (!busy_q || (adv && k_q == 3'd7));

  // Mirror the current point into the k-th octant.
  always_comb begin
    xs = CoordW'(pt_q.x);
    ys = CoordW'(pt_q.y);
    unique case (k_q)
      3'd0: begin px = xs;  py = ys;  end
      3'd1: begin px = xs;  py = -ys; end
      3'd2: begin px = ys;  py = -xs; end
      3'd3: begin px = -ys; py = -xs; end
      3'd4: begin px = -xs; py = -ys; end
      3'd5: begin px = -xs; py = ys;  end
      3'd6: begin px = -ys; py = xs;  end
      3'd7: begin px = ys;  py = xs;  end
      default: begin px = '0; py = '0; end
    endcase
    sx = CoordW'(center_x_i) + px;
    sy = CoordW'(center_y_i) - py;
  end

  always_comb begin
    pt_d        = pt_q;
    busy_d      = busy_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (adv) begin
      out_valid_d = 1'b1;
      k_d         = k_q + 3'd1;
      if (k_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end
    if (pt_pop_o) begin
      pt_d   = pt_i;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q <= pt_d;
    if (adv) begin
      pix_x_q <= sx;
      pix_y_q <= sy;
      color_q <= color_i;
      lastp_q <= k_q == 3'd7;
      lastc_q <= pt_q.last_circle;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pixel_x_o        = $signed(pix_x_q);
  assign pixel_y_o        = $signed(pix_y_q);
  assign color_out_o      = color_q;
  assign last_of_point_o  = lastp_q;
  assign last_of_circle_o = lastc_q;

  `COR_ASSERT(a_back_idle_k_zero, !busy_q |-> k_q == '0, "octant counter moved while idle")
  `COR_ASSERT(a_back_last_mark, adv && k_q == 3'd7 |=> out_valid_q && lastp_q,
              "eighth pixel not marked last")
  `COR_ASSERT(a_back_pop_free, pt_pop_o |-> !busy_q || k_q == 3'd7, "point popped mid-run")

endmodule
